// File: src/mmai_pkg.sv
// package: shared types, constants and codes of the modq montgomery arithmetic core
`timescale 1ns / 1ps
`default_nettype none
package mmai_pkg;

   localparam logic [2:0] ACT_REDUCE = 3'd0;
   localparam logic [2:0] ACT_MUL    = 3'd1;
   localparam logic [2:0] ACT_FOLD   = 3'd2;
   localparam logic [2:0] ACT_CSUB   = 3'd3;
   localparam logic [2:0] ACT_INV    = 3'd4;

   localparam logic [15:0] MODQ     = 16'd3457;
   localparam logic [15:0] QINV     = 16'd12929;
   localparam logic [11:0] LOW_MASK = 12'hFFF;
   localparam int          FOLD_MUL = 639;

   // inverse chain: 11 squarings and 9 multiplies by a
   localparam int          NUM_MM      = 20;
   localparam logic [NUM_MM-1:0] SQUARE_MASK = 20'b0101_0101_0101_0110_1101;

   localparam int QUEUE_DEPTH_DEF = 2;

   typedef enum logic [1:0] {
      KIND_DIRECT,
      KIND_REDUCE,
      KIND_MUL,
      KIND_INV
   } kind_type;

   typedef struct packed {
      logic        valid;
      kind_type    kind;
      logic [31:0] wide;
      logic [15:0] a;
      logic [15:0] b;
      logic [15:0] t;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic pop;
   } queue_stat_type;

endpackage
`default_nettype wire

// File: src/mmai_if.sv
// interfaces: request and response channels of the modq montgomery arithmetic core
`timescale 1ns / 1ps
`default_nettype none
interface mmai_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [31:0] wide_operand;
   logic [15:0] operand_a;
   logic [15:0] operand_b;
   modport source(output valid, action, wide_operand, operand_a, operand_b, input ready);
   modport sink(input valid, action, wide_operand, operand_a, operand_b, output ready);
endinterface

interface mmai_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] result;
   modport source(output valid, result, input ready);
   modport sink(input valid, result, output ready);
endinterface
`default_nettype wire

// File: src/mmai_queue.sv
// queue: short fifo between the front classifier and the back pipeline
`timescale 1ns / 1ps
`default_nettype none
module mmai_queue
   import mmai_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push_valid,
   input  wire item_type push_item,
   output logic          push_ready,
   input  wire logic     pop_ready,
   output logic          pop_valid,
   output item_type      pop_item,
   output queue_stat_type stat
);
   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

   item_type      mem [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          full, empty, push, pop;

   always_comb begin
      full       = (count_ff == FULL_COUNT);
      empty      = (count_ff == '0);
      pop        = pop_ready && !empty;
      push_ready = !full || pop;
      push       = push_valid && push_ready;
      pop_valid  = !empty;
      pop_item   = mem[rd_ptr_ff];
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CW'(push) - CW'(pop);
      stat     = '{full: full, empty: empty, pop: pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end
endmodule
`default_nettype wire

// File: src/mmai_front.sv
// front: accepts request beats, classifies them and computes the cheap operations
`timescale 1ns / 1ps
`default_nettype none
module mmai_front
   import mmai_pkg::*;
(
   mmai_req_if.sink  req_ch,
   input  wire logic q_ready,
   output logic      q_valid,
   output item_type  q_item
);
   logic signed [16:0] fold_sum;
   logic [15:0]        csub;

   always_comb begin
      // fold: low 12 bits plus 639 times the signed high nibble
      fold_sum = $signed({5'b0, req_ch.operand_a[11:0] & LOW_MASK})
               + 17'($signed(req_ch.operand_a[15:12]) * 17'sd639);
      csub = req_ch.operand_a;
      if (csub[15]) begin
         csub = csub + MODQ;
      end
      csub = csub - MODQ;
      if (csub[15]) begin
         csub = csub + MODQ;
      end

      q_item.valid = 1'b1;
      q_item.wide  = req_ch.wide_operand;
      q_item.a     = req_ch.operand_a;
      q_item.b     = req_ch.operand_b;
      q_item.kind  = KIND_DIRECT;
      q_item.t     = '0;
      case (req_ch.action)
         ACT_REDUCE: q_item.kind = KIND_REDUCE;
         ACT_MUL:    q_item.kind = KIND_MUL;
         ACT_FOLD:   q_item.t    = fold_sum[15:0];
         ACT_CSUB:   q_item.t    = csub;
         ACT_INV: begin
            q_item.kind = KIND_INV;
            q_item.t    = req_ch.operand_a;
         end
         default:    q_item.t    = '0;
      endcase
      q_valid      = req_ch.valid;
      req_ch.ready = q_ready;
   end
endmodule
`default_nettype wire

// File: src/mmai_mm_stage.sv
// montgomery multiply stage: product, low-word quotient, then reduction
`timescale 1ns / 1ps
`default_nettype none
module mmai_mm_stage
   import mmai_pkg::*;
#(
   parameter bit FIRST  = 1'b0,
   parameter bit SQUARE = 1'b0
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     en,
   input  wire item_type in_item,
   output item_type      out_item
);
   item_type           s1_ff, s2_ff, s3_ff;
   logic [31:0]        p1_ff, p1_in, p2_ff;
   logic [15:0]        u2_ff, u2_in;
   logic               act1_ff, act1_in, act2_ff;
   logic [15:0]        lhs, rhs, r3_in;
   logic [31:0]        uprod;
   logic signed [28:0] uq;
   logic [31:0]        t32;
   logic               first_mul, first_red;

   always_comb begin
      first_mul = FIRST && (in_item.kind == KIND_MUL);
      first_red = FIRST && (in_item.kind == KIND_REDUCE);
      act1_in   = in_item.kind == KIND_INV || first_mul || first_red;
      lhs       = first_mul ? in_item.a : in_item.t;
      rhs       = first_mul ? in_item.b : (SQUARE ? in_item.t : in_item.a);
      p1_in     = first_red ? in_item.wide : 32'($signed(lhs)) * 32'($signed(rhs));
      uprod     = p1_ff[15:0] * QINV;
      u2_in     = uprod[15:0];
      uq        = $signed(u2_ff) * $signed(13'd3457);
      t32       = p2_ff - {{3{uq[28]}}, uq};
      r3_in     = act2_ff ? t32[31:16] : s2_ff.t;
      out_item  = s3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
      end else if (en) begin
         s1_ff.valid <= in_item.valid;
         s2_ff.valid <= s1_ff.valid;
         s3_ff.valid <= s2_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff.kind <= in_item.kind;
         s1_ff.wide <= in_item.wide;
         s1_ff.a    <= in_item.a;
         s1_ff.b    <= in_item.b;
         s1_ff.t    <= in_item.t;
         p1_ff      <= p1_in;
         act1_ff    <= act1_in;
         s2_ff.kind <= s1_ff.kind;
         s2_ff.wide <= s1_ff.wide;
         s2_ff.a    <= s1_ff.a;
         s2_ff.b    <= s1_ff.b;
         s2_ff.t    <= s1_ff.t;
         p2_ff      <= p1_ff;
         u2_ff      <= u2_in;
         act2_ff    <= act1_ff;
         s3_ff.kind <= s2_ff.kind;
         s3_ff.wide <= s2_ff.wide;
         s3_ff.a    <= s2_ff.a;
         s3_ff.b    <= s2_ff.b;
         s3_ff.t    <= r3_in;
      end
   end
endmodule
`default_nettype wire

// File: src/mmai_back.sv
// back: fixed chain of montgomery multiply stages that carries out each item
`timescale 1ns / 1ps
`default_nettype none
module mmai_back
   import mmai_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     en,
   input  wire item_type in_item,
   output item_type      out_item
);
   item_type chain [NUM_MM+1];

   assign chain[0] = in_item;

   for (genvar k = 0; k < NUM_MM; k++) begin : g_mm
      mmai_mm_stage #(
         .FIRST  (k == 0),
         .SQUARE (SQUARE_MASK[k])
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_item  (chain[k]),
         .out_item (chain[k+1])
      );
   end

   assign out_item = chain[NUM_MM];
endmodule
`default_nettype wire

// File: src/modq_montgomery_arith_inverse_core.sv
// top level: modq 3457 montgomery arithmetic and fixed-chain inverse core
// One beat per cycle is accepted while the queue has room, and one result beat is returned for each, in order.
// A request beat is first written into the queue, whose pop loads the first of the 60
// registers of the back chain of 20 montgomery multiply stages of 3 registers each, which
// every operation traverses so that order is kept; the last register of the last stage is
// the output register.
// A stalled response freezes the chain, and the queue absorbs the beat in flight.
`timescale 1ns / 1ps
`default_nettype none
module modq_montgomery_arith_inverse_core
   import mmai_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   mmai_req_if.sink   req_ch,
   mmai_rsp_if.source rsp_ch
);
   item_type       f_item, q_item, b_in, b_out;
   logic           f_valid, q_ready, q_valid, en;
   queue_stat_type q_stat;

   mmai_front u_front (
      .req_ch  (req_ch),
      .q_ready (q_ready),
      .q_valid (f_valid),
      .q_item  (f_item)
   );

   mmai_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_item  (f_item),
      .push_ready (q_ready),
      .pop_ready  (en),
      .pop_valid  (q_valid),
      .pop_item   (q_item),
      .stat       (q_stat)
   );

   always_comb begin
      en         = !b_out.valid || rsp_ch.ready;
      b_in       = q_item;
      b_in.valid = q_valid;
   end

   mmai_back u_back (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_item  (b_in),
      .out_item (b_out)
   );

   assign rsp_ch.valid  = b_out.valid;
   assign rsp_ch.result = b_out.t;

`ifndef NO_ASSERTIONS
   a_not_full_and_empty: assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty)) else $error("queue full and empty at once");
   a_pop_needs_advance: assert property (@(posedge clock) disable iff (reset)
      q_stat.pop |-> (en && !q_stat.empty)) else $error("queue popped while chain stalled");
   a_accept_has_room: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |-> (!q_stat.full || q_stat.pop))
      else $error("beat accepted into full queue");
   a_stall_holds_output: assert property (@(posedge clock) disable iff (reset)
      (b_out.valid && !rsp_ch.ready) |=> b_out.valid) else $error("stalled result dropped");
`endif
endmodule
`default_nettype wire
